/* design/ole_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the ordered list engine.
// Used by ole_ctrl, ole_datapath, ordered_list_engine and the testbench; depends on nothing else.
package ole_pkg;

    // Field widths of the command and result beats.
    localparam int OP_W  = 3;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 6;

    // Default list capacity.
    localparam int CAPACITY_DEFAULT = 32;

    // Command opcodes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    // Datapath actions requested by the controller.
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_ROTATE     = 3'd6;

    typedef logic signed [VAL_W-1:0] t_value;

    // One command beat.
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        t_value           value_in;
    } t_cmd_in;

    // One result beat.
    typedef struct packed {
        t_value           value_out;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic             load;
        logic [ACT_W-1:0] act;
        logic             emit;
        logic [ST_W-1:0]  status;
        logic             last;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            pos_ok;
        logic            dump_last;
    } t_dp_stat;

endpackage

/* design/ole_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the ordered list engine.
// Depends on ole_pkg; drives ole_datapath through t_dp_cmd and reads t_dp_stat.
module ole_ctrl
    import ole_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_busy = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.act    = ACT_NONE;
        o_cmd.emit   = 1'b0;
        o_cmd.status = ST_OK;
        o_cmd.last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_IDLE;
                o_cmd.emit = 1'b1;
                unique case (i_stat.op)
                    OP_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.act = ACT_PUSH_FRONT;
                        end
                    end
                    OP_INSERT: begin
                        if (!i_stat.pos_ok) begin
                            o_cmd.status = ST_BADPOS;
                        end else if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.act = ACT_INSERT;
                        end
                    end
                    OP_PUSH_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.act = ACT_PUSH_BACK;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.act = ACT_POP_FRONT;
                        end
                    end
                    OP_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.act = ACT_POP_BACK;
                        end
                    end
                    OP_DUMP: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            // Elements go out one beat per cycle from the dump state.
                            o_cmd.emit = 1'b0;
                            n_state    = S_DUMP;
                        end
                    end
                    default: begin
                        // Unused opcodes answer ok and change nothing.
                    end
                endcase
            end
            S_DUMP: begin
                o_cmd.act  = ACT_ROTATE;
                o_cmd.emit = 1'b1;
                o_cmd.last = i_stat.dump_last;
                if (i_stat.dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/ole_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the ordered list engine: the row of list cells, the element count,
// the latched command and the result register. Depends on ole_pkg.
module ole_datapath
    import ole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd_in  i_cmd,
    input  t_dp_cmd  i_ctl,
    output t_dp_stat o_stat,
    output logic     o_result_strobe,
    output t_result  o_result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Latched command.
    logic [OP_W-1:0]  r_op;
    logic [POS_W-1:0] r_pos;
    t_value           r_val;

    // List cells, front at index 0, and the element count.
    t_value           r_cells [CAPACITY];
    t_value           n_cells [CAPACITY];
    t_value           w_up    [CAPACITY];
    t_value           w_dn    [CAPACITY];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    w_cnt_m1;
    logic [CW-1:0]    w_ins_idx;
    logic [CW-1:0]    r_dump_idx;

    // Result register.
    logic             r_strobe;
    t_result          r_result;
    t_value           w_value;

    assign w_cnt_m1 = r_count - CW'(1);

    // Neighbor taps of each cell.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
        if (g < CAPACITY - 1) begin : g_up
            assign w_up[g] = r_cells[g+1];
        end else begin : g_up_end
            assign w_up[g] = r_cells[g];
        end
        if (g > 0) begin : g_dn
            assign w_dn[g] = r_cells[g-1];
        end else begin : g_dn_end
            assign w_dn[g] = r_cells[g];
        end
    end

    // Status toward the controller.
    assign o_stat.op        = r_op;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(CAPACITY));
    assign o_stat.pos_ok    = (r_pos != '0) && (CMPW'(r_pos) <= CMPW'(r_count));
    assign o_stat.dump_last = (r_dump_idx == w_cnt_m1);

    // Slot that an insert writes.
    always_comb begin
        case (i_ctl.act)
            ACT_INSERT:    w_ins_idx = CW'(r_pos);
            ACT_PUSH_BACK: w_ins_idx = r_count;
            default:       w_ins_idx = '0;
        endcase
    end

    // Next cell contents and count.
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
        end
        case (i_ctl.act) inside
            ACT_PUSH_FRONT, ACT_INSERT, ACT_PUSH_BACK: begin
                n_count = r_count + CW'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                    if (CW'(i) == w_ins_idx) begin
                        n_cells[i] = r_val;
                    end else if (CW'(i) > w_ins_idx) begin
                        n_cells[i] = w_dn[i];
                    end
                end
            end
            ACT_POP_FRONT: begin
                n_count = w_cnt_m1;
                for (int i = 0; i < CAPACITY; i++) begin
                    n_cells[i] = w_up[i];
                end
            end
            ACT_POP_BACK: begin
                n_count = w_cnt_m1;
            end
            ACT_ROTATE: begin
                // The front element moves to the back, so the list is whole after the dump.
                for (int i = 0; i < CAPACITY; i++) begin
                    n_cells[i] = (CW'(i) == w_cnt_m1) ? r_cells[0] : w_up[i];
                end
            end
            default: begin
            end
        endcase
    end

    // Value carried by the result beat.
    always_comb begin
        case (i_ctl.act) inside
            ACT_POP_FRONT, ACT_ROTATE: w_value = r_cells[0];
            ACT_POP_BACK:              w_value = r_cells[w_cnt_m1[IW-1:0]];
            default:                   w_value = '0;
        endcase
    end

    // Command latch and list cells.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op  <= i_cmd.opcode;
            r_pos <= i_cmd.position;
            r_val <= i_cmd.value_in;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            r_cells[i] <= n_cells[i];
        end
        r_result.value_out <= w_value;
        r_result.status    <= i_ctl.status;
        r_result.length    <= LEN_W'(n_count);
        r_result.last      <= i_ctl.last;
    end

    // Count, dump position and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_dump_idx <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_ctl.emit;
            if (i_ctl.load) begin
                r_dump_idx <= '0;
            end else if (i_ctl.act == ACT_ROTATE) begin
                r_dump_idx <= r_dump_idx + CW'(1);
            end
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

/* design/ordered_list_engine.sv */
`timescale 1ns / 1ps
// Ordered list engine: a bounded list of signed 32-bit values with push, insert,
// pop and dump commands. Depends on ole_pkg, ole_ctrl and ole_datapath.
//
// A command beat is taken at a rising edge with i_start high and o_busy low. Every
// command except a dump gives one result beat, on the result port for the one cycle
// that o_result_strobe is high, after the command has passed the execute state and
// the result register; o_busy drops in that same cycle, so the next command can be
// taken at the end of that cycle. A dump of n elements gives n beats on consecutive
// cycles, front first, with last set on the final one; an empty dump gives one beat
// with status empty. Inserts and pops move the whole row of cells together. Results
// cannot be held off: the receiver must take each beat in the cycle it is shown.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    input  t_cmd_in i_cmd,
    output logic    o_result_strobe,
    output t_result o_result
);

    t_dp_cmd  w_ctl;
    t_dp_stat w_stat;

    // Sequencing of each command.
    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (w_stat),
        .o_cmd   (w_ctl)
    );

    // List storage and result register.
    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_ctl           (w_ctl),
        .o_stat          (w_stat),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

/* tb/tb_ordered_list_engine.sv */
`timescale 1ns / 1ps
// Testbench for ordered_list_engine: directed and random list commands are driven and
// each result beat is checked against a list model in the bench. Depends on ole_pkg.
module tb_ordered_list_engine;
    import ole_pkg::*;

    localparam int LIST_CAP      = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = LIST_CAP + 8;
    localparam int RANDOM_ITEMS  = 130;

    // Opcodes that the package leaves unnamed; the block must treat them as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // A command waiting to be driven, with its idle chance and drain request.
    typedef struct {
        t_cmd_in cmd;
        int      gap_pct;
        bit      wait_drain;
    } t_pending;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd_in i_cmd   = '0;
    logic    o_busy;
    logic    o_result_strobe;
    t_result o_result;

    t_value   list_model[$];
    t_result  expected_beats[$];
    t_pending cmd_backlog[$];
    t_cmd_in  cmd_on_bus;
    int       beats_due   = 0;
    int       beats_seen  = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    // Stimulus generation state: a shadow element count, the idle chance, a drain flag.
    int gen_count = 0;
    int gen_gap   = 15;
    bit gen_drain = 1'b0;

    ordered_list_engine #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Queue one command and track the element count it leaves behind.
    task automatic queue_cmd(input logic [OP_W-1:0] op, input int pos, input t_value val);
        t_pending p;
        p.cmd.opcode   = op;
        p.cmd.position = pos[POS_W-1:0];
        p.cmd.value_in = val;
        p.gap_pct      = gen_gap;
        p.wait_drain   = gen_drain;
        gen_drain      = 1'b0;
        cmd_backlog.push_back(p);
        case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (gen_count < LIST_CAP) gen_count++;
            end
            OP_INSERT: begin
                if (pos >= 1 && pos <= gen_count && gen_count < LIST_CAP) gen_count++;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (gen_count > 0) gen_count--;
            end
            default: ;
        endcase
    endtask

    // Apply one accepted command to the list model and record the beats it must produce.
    task automatic apply_list_cmd(input t_cmd_in c);
        t_result r;
        int      n;
        n           = list_model.size();
        r.value_out = '0;
        r.status    = ST_OK;
        r.last      = 1'b1;
        if (c.opcode == OP_DUMP && n != 0) begin
            // A dump walks the list front to back, one beat per element.
            for (int i = 0; i < n; i++) begin
                r.value_out = list_model[i];
                r.length    = n[LEN_W-1:0];
                r.last      = (i == n - 1);
                expected_beats.push_back(r);
                beats_due++;
            end
        end else begin
            case (c.opcode)
                OP_PUSH_FRONT: begin
                    if (n >= LIST_CAP) r.status = ST_FULL;
                    else list_model.push_front(c.value_in);
                end
                OP_INSERT: begin
                    // Position is checked before capacity.
                    if (int'(c.position) < 1 || int'(c.position) > n) r.status = ST_BADPOS;
                    else if (n >= LIST_CAP) r.status = ST_FULL;
                    else list_model.insert(int'(c.position), c.value_in);
                end
                OP_PUSH_BACK: begin
                    if (n >= LIST_CAP) r.status = ST_FULL;
                    else list_model.push_back(c.value_in);
                end
                OP_POP_FRONT: begin
                    if (n == 0) r.status = ST_EMPTY;
                    else r.value_out = list_model.pop_front();
                end
                OP_POP_BACK: begin
                    if (n == 0) r.status = ST_EMPTY;
                    else r.value_out = list_model.pop_back();
                end
                OP_DUMP: begin
                    r.status = ST_EMPTY;
                end
                default: ;
            endcase
            r.length = LEN_W'(list_model.size());
            expected_beats.push_back(r);
            beats_due++;
        end
    endtask

    // Driver: feeds the backlog to the block, with random gaps and optional drains.
    always @(posedge i_clk) begin : driver
        bit       raise;
        t_pending nxt;
        raise = 1'b0;
        if (i_rst_n) begin
            if (i_start && !o_busy) apply_list_cmd(cmd_on_bus);
            if (i_start && o_busy) begin
                raise = 1'b1;
            end else if (cmd_backlog.size() != 0) begin
                if ((!cmd_backlog[0].wait_drain || beats_seen == beats_due)
                        && $urandom_range(99) >= cmd_backlog[0].gap_pct) begin
                    nxt        = cmd_backlog.pop_front();
                    cmd_on_bus = nxt.cmd;
                    raise      = 1'b1;
                end
            end
        end
        i_start <= raise;
        if (raise) i_cmd <= cmd_on_bus;
    end

    // Monitor: every result beat is compared with the oldest expected beat.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            beats_seen <= beats_seen + 1;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: value_out %0d status %0d length %0d last %0d",
                       o_result.value_out, o_result.status, o_result.length, o_result.last);
                error_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_result.value_out !== want.value_out) begin
                    $error("value_out: expected %0d, got %0d",
                           want.value_out, o_result.value_out);
                    error_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    error_count++;
                end
                if (o_result.length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, o_result.length);
                    error_count++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_ordered_list_engine NOT OK");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        bit grow;
        int pick;
        int pos;

        // Directed part: empty list cases, field extremes, bad positions, spare opcodes.
        queue_cmd(OP_DUMP, 0, '0);
        queue_cmd(OP_POP_FRONT, 0, '0);
        queue_cmd(OP_POP_BACK, 63, '0);
        queue_cmd(OP_INSERT, 1, 32'sd5);
        queue_cmd(OP_PUSH_FRONT, 0, 32'sh7FFF_FFFF);
        queue_cmd(OP_PUSH_BACK, 0, 32'sh8000_0000);
        queue_cmd(OP_INSERT, 0, 32'sd9);
        queue_cmd(OP_INSERT, 2, -32'sd1);
        queue_cmd(OP_INSERT, 1, '0);
        queue_cmd(OP_INSERT, 5, 32'sd11);
        queue_cmd(OP_INSERT, 63, 32'sd12);
        queue_cmd(OP_SPARE_6, 21, 32'sh5555_5555);
        queue_cmd(OP_SPARE_7, 63, -32'sd1);
        queue_cmd(OP_DUMP, 42, '0);
        queue_cmd(OP_POP_FRONT, 0, '0);
        queue_cmd(OP_POP_BACK, 0, '0);
        queue_cmd(OP_DUMP, 0, '0);
        queue_cmd(OP_PUSH_BACK, 0, 32'shAAAA_AAAA);
        queue_cmd(OP_PUSH_FRONT, 0, 32'sh5555_5555);

        // Random part: phases that grow the list to full and shrink it to empty, with random content.
        grow = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3) begin
                gen_gap   = 63;
                gen_drain = 1'b1;
            end
            if (k == 2 * RANDOM_ITEMS / 3) begin
                gen_gap   = 0;
                gen_drain = 1'b1;
            end
            if ($urandom_range(99) < 4) gen_drain = 1'b1;
            if (grow && gen_count == LIST_CAP && $urandom_range(99) < 30) grow = 1'b0;
            if (!grow && gen_count == 0 && $urandom_range(99) < 40) grow = 1'b1;

            if (gen_count > 0 && $urandom_range(9) < 8) pos = $urandom_range(gen_count, 1);
            else pos = $urandom_range(63);

            pick = $urandom_range(99);
            if (grow) begin
                if (pick < 30) queue_cmd(OP_PUSH_FRONT, $urandom_range(63), $urandom());
                else if (pick < 55) queue_cmd(OP_PUSH_BACK, $urandom_range(63), $urandom());
                else if (pick < 80) queue_cmd(OP_INSERT, pos, $urandom());
                else if (pick < 85) queue_cmd(OP_POP_FRONT, $urandom_range(63), $urandom());
                else if (pick < 89) queue_cmd(OP_POP_BACK, $urandom_range(63), $urandom());
                else if (pick < 95) queue_cmd(OP_DUMP, $urandom_range(63), $urandom());
                else if (pick < 98) queue_cmd(OP_SPARE_6, $urandom_range(63), $urandom());
                else queue_cmd(OP_SPARE_7, $urandom_range(63), $urandom());
            end else begin
                if (pick < 35) queue_cmd(OP_POP_FRONT, $urandom_range(63), $urandom());
                else if (pick < 70) queue_cmd(OP_POP_BACK, $urandom_range(63), $urandom());
                else if (pick < 74) queue_cmd(OP_PUSH_FRONT, $urandom_range(63), $urandom());
                else if (pick < 77) queue_cmd(OP_PUSH_BACK, $urandom_range(63), $urandom());
                else if (pick < 81) queue_cmd(OP_INSERT, pos, $urandom());
                else if (pick < 93) queue_cmd(OP_DUMP, $urandom_range(63), $urandom());
                else if (pick < 97) queue_cmd(OP_SPARE_6, $urandom_range(63), $urandom());
                else queue_cmd(OP_SPARE_7, $urandom_range(63), $urandom());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command is taken and every beat has come back.
        while (cmd_backlog.size() != 0 || i_start) @(negedge i_clk);
        while (beats_seen != beats_due) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (expected_beats.size() != 0) begin
            $error("%0d expected result beats never arrived", expected_beats.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_ordered_list_engine OK");
        end else begin
            $display("tb_ordered_list_engine NOT OK");
        end
        $finish;
    end

endmodule

/* ordered_list_engine.f */
design/ole_pkg.sv
design/ole_ctrl.sv
design/ole_datapath.sv
design/ordered_list_engine.sv
tb/tb_ordered_list_engine.sv
